/* src/dlle_pkg.sv */
`default_nettype none

package dlle_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned IDX_W    = $clog2(CAPACITY + 1);
  localparam int unsigned VALUE_W  = 32;

  // link value that means "no node"
  localparam logic [IDX_W-1:0] IDX_NONE = IDX_W'(CAPACITY);
  localparam logic [IDX_W-1:0] STEP_END = IDX_W'(CAPACITY - 1);

  typedef enum logic [2:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_DELETE    = 3'd2,
    ACT_WALK_FWD  = 3'd3,
    ACT_WALK_BWD  = 3'd4,
    ACT_CLEAR     = 3'd5
  } dlle_action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } dlle_status_e;

  typedef enum logic [1:0] {
    VSEL_CMD  = 2'd0,
    VSEL_ZERO = 2'd1,
    VSEL_NODE = 2'd2
  } dlle_vsel_e;

  typedef enum logic [2:0] {
    CUR_HOLD = 3'd0,
    CUR_HEAD = 3'd1,
    CUR_TAIL = 3'd2,
    CUR_NEXT = 3'd3,
    CUR_PREV = 3'd4
  } dlle_cur_e;

  typedef struct packed {
    logic         latch;
    dlle_cur_e    cur_op;
    logic         step_clr;
    logic         step_inc;
    logic         alloc;
    logic         ins_link;
    logic         ins_end;
    logic         front;
    logic         unlink;
    logic         clear;
    logic         out_load;
    dlle_vsel_e   out_sel;
    dlle_status_e out_status;
    logic         out_last;
  } dlle_cmd_t;

  typedef struct packed {
    dlle_action_e action;
    logic         pool_full;
    logic         head_none;
    logic         tail_none;
    logic         node_match;
    logic         next_none;
    logic         prev_none;
    logic         step_end;
    logic         out_free;
  } dlle_stat_t;

endpackage

`default_nettype wire

/* src/dlle_ram.sv */
`default_nettype none

module dlle_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* src/dlle_datapath.sv */
`default_nettype none

module dlle_datapath (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic [2:0]                           action_i,
  input  wire logic signed [dlle_pkg::VALUE_W-1:0]  value_i,
  input  wire dlle_pkg::dlle_cmd_t                  cmd_i,
  output dlle_pkg::dlle_stat_t                      stat_o,
  input  wire logic                                 out_stall_i,
  output logic                                      out_valid_o,
  output logic signed [dlle_pkg::VALUE_W-1:0]       out_value_o,
  output logic [1:0]                                status_o,
  output logic                                      is_last_o
);

  dlle_pkg::dlle_action_e              action_q;
  logic [dlle_pkg::VALUE_W-1:0]        cmd_value_q;
  logic [dlle_pkg::IDX_W-1:0]          head_q, head_d;
  logic [dlle_pkg::IDX_W-1:0]          tail_q, tail_d;
  logic [dlle_pkg::CAPACITY-1:0]       free_q, free_d;
  logic [dlle_pkg::IDX_W-1:0]          cur_q, cur_d;
  logic [dlle_pkg::IDX_W-1:0]          step_q;
  logic [dlle_pkg::ADDR_W-1:0]         new_q;
  logic [dlle_pkg::ADDR_W-1:0]         alloc_idx;
  logic                                alloc_found;

  logic                                out_valid_q;
  logic [dlle_pkg::VALUE_W-1:0]        out_value_q;
  dlle_pkg::dlle_status_e              out_status_q;
  logic                                out_last_q;
  logic                                out_free;

  logic [dlle_pkg::VALUE_W-1:0]        node_val_rd;
  logic [dlle_pkg::IDX_W-1:0]          next_rd, prev_rd;
  logic                                head_none, tail_none, next_none, prev_none;

  logic                                next_we, prev_we;
  logic [dlle_pkg::ADDR_W-1:0]         next_waddr, prev_waddr;
  logic [dlle_pkg::IDX_W-1:0]          next_wdata, prev_wdata;
  logic [dlle_pkg::IDX_W-1:0]          new_link;

  assign head_none = (head_q >= dlle_pkg::IDX_NONE);
  assign tail_none = (tail_q >= dlle_pkg::IDX_NONE);
  assign next_none = (next_rd >= dlle_pkg::IDX_NONE);
  assign prev_none = (prev_rd >= dlle_pkg::IDX_NONE);
  assign new_link  = dlle_pkg::IDX_W'(new_q);
  assign out_free  = !out_valid_q || !out_stall_i;

  // lowest free node
  always_comb begin
    alloc_idx   = '0;
    alloc_found = 1'b0;
    for (int i = 0; i < dlle_pkg::CAPACITY; i++) begin
      if (free_q[i] && !alloc_found) begin
        alloc_idx   = dlle_pkg::ADDR_W'(i);
        alloc_found = 1'b1;
      end
    end
  end

  // read address follows the next cursor so read data lines up with cur_q
  always_comb begin
    case (cmd_i.cur_op)
      dlle_pkg::CUR_HEAD: cur_d = head_q;
      dlle_pkg::CUR_TAIL: cur_d = tail_q;
      dlle_pkg::CUR_NEXT: cur_d = next_rd;
      dlle_pkg::CUR_PREV: cur_d = prev_rd;
      default:            cur_d = cur_q;
    endcase
  end

  always_comb begin
    next_we    = 1'b0;
    next_waddr = new_q;
    next_wdata = dlle_pkg::IDX_NONE;
    if (cmd_i.ins_link) begin
      next_we    = 1'b1;
      next_wdata = cmd_i.front ? head_q : dlle_pkg::IDX_NONE;
    end else if (cmd_i.ins_end && !cmd_i.front && !tail_none) begin
      next_we    = 1'b1;
      next_waddr = tail_q[dlle_pkg::ADDR_W-1:0];
      next_wdata = new_link;
    end else if (cmd_i.unlink && !prev_none) begin
      next_we    = 1'b1;
      next_waddr = prev_rd[dlle_pkg::ADDR_W-1:0];
      next_wdata = next_rd;
    end
  end

  always_comb begin
    prev_we    = 1'b0;
    prev_waddr = new_q;
    prev_wdata = dlle_pkg::IDX_NONE;
    if (cmd_i.ins_link) begin
      prev_we    = 1'b1;
      prev_wdata = cmd_i.front ? dlle_pkg::IDX_NONE : tail_q;
    end else if (cmd_i.ins_end && cmd_i.front && !head_none) begin
      prev_we    = 1'b1;
      prev_waddr = head_q[dlle_pkg::ADDR_W-1:0];
      prev_wdata = new_link;
    end else if (cmd_i.unlink && !next_none) begin
      prev_we    = 1'b1;
      prev_waddr = next_rd[dlle_pkg::ADDR_W-1:0];
      prev_wdata = prev_rd;
    end
  end

  dlle_ram #(.WIDTH(dlle_pkg::VALUE_W), .DEPTH(dlle_pkg::CAPACITY)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ins_link),
    .waddr_i (new_q),
    .wdata_i (cmd_value_q),
    .raddr_i (cur_d[dlle_pkg::ADDR_W-1:0]),
    .rdata_o (node_val_rd)
  );

  dlle_ram #(.WIDTH(dlle_pkg::IDX_W), .DEPTH(dlle_pkg::CAPACITY)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (cur_d[dlle_pkg::ADDR_W-1:0]),
    .rdata_o (next_rd)
  );

  dlle_ram #(.WIDTH(dlle_pkg::IDX_W), .DEPTH(dlle_pkg::CAPACITY)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .raddr_i (cur_d[dlle_pkg::ADDR_W-1:0]),
    .rdata_o (prev_rd)
  );

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    free_d = free_q;
    if (cmd_i.clear) begin
      head_d = dlle_pkg::IDX_NONE;
      tail_d = dlle_pkg::IDX_NONE;
      free_d = '1;
    end
    if (cmd_i.alloc) begin
      free_d[alloc_idx] = 1'b0;
    end
    if (cmd_i.ins_end) begin
      if (cmd_i.front) begin
        head_d = new_link;
        if (head_none) tail_d = new_link;
      end else begin
        tail_d = new_link;
        if (tail_none) head_d = new_link;
      end
    end
    if (cmd_i.unlink) begin
      if (prev_none) head_d = next_rd;
      if (next_none) tail_d = prev_rd;
      free_d[cur_q[dlle_pkg::ADDR_W-1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= dlle_pkg::IDX_NONE;
      tail_q      <= dlle_pkg::IDX_NONE;
      free_q      <= '1;
      cur_q       <= dlle_pkg::IDX_NONE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      free_q <= free_d;
      cur_q  <= cur_d;
      if (cmd_i.step_clr) begin
        step_q <= '0;
      end else if (cmd_i.step_inc) begin
        step_q <= step_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      action_q    <= dlle_pkg::dlle_action_e'(action_i);
      cmd_value_q <= value_i;
    end
    if (cmd_i.alloc) begin
      new_q <= alloc_idx;
    end
    if (cmd_i.out_load) begin
      case (cmd_i.out_sel)
        dlle_pkg::VSEL_NODE: out_value_q <= node_val_rd;
        dlle_pkg::VSEL_ZERO: out_value_q <= '0;
        default:             out_value_q <= cmd_value_q;
      endcase
      out_status_q <= cmd_i.out_status;
      out_last_q   <= cmd_i.out_last;
    end
  end

  always_comb begin
    stat_o.action     = action_q;
    stat_o.pool_full  = ~|free_q;
    stat_o.head_none  = head_none;
    stat_o.tail_none  = tail_none;
    stat_o.node_match = (node_val_rd == cmd_value_q);
    stat_o.next_none  = next_none;
    stat_o.prev_none  = prev_none;
    stat_o.step_end   = (step_q == dlle_pkg::STEP_END);
    stat_o.out_free   = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign status_o    = out_status_q;
  assign is_last_o   = out_last_q;

  a_head_tail_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_none == tail_none)
    else $error("head and tail disagree on list emptiness");

  a_all_free_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_q == '1) |-> head_none)
    else $error("list has a head while every node is free");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("output word overwritten while stalled");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= dlle_pkg::STEP_END)
    else $error("walk step counter past pool size");

endmodule

`default_nettype wire

/* src/dlle_ctrl.sv */
`default_nettype none

module dlle_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire dlle_pkg::dlle_stat_t stat_i,
  output dlle_pkg::dlle_cmd_t       cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_INS_LINK = 7'b0000100,
    S_INS_END  = 7'b0001000,
    S_DEL_SCAN = 7'b0010000,
    S_WALK     = 7'b0100000,
    S_EMIT     = 7'b1000000
  } state_e;

  state_e                 state_q, state_d;
  dlle_pkg::dlle_status_e status_q, status_d;
  dlle_pkg::dlle_vsel_e   vsel_q, vsel_d;
  logic                   walk_fwd;
  logic                   walk_stop;

  assign in_stall_o = (state_q != S_IDLE);
  assign walk_fwd   = (stat_i.action == dlle_pkg::ACT_WALK_FWD);
  // last word of a walk: no further link, or the pool size reached
  assign walk_stop  = (walk_fwd ? stat_i.next_none : stat_i.prev_none) || stat_i.step_end;

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    vsel_d   = vsel_q;
    cmd_o            = '0;
    cmd_o.cur_op     = dlle_pkg::CUR_HOLD;
    cmd_o.out_sel    = vsel_q;
    cmd_o.out_status = status_q;
    cmd_o.front      = (stat_i.action == dlle_pkg::ACT_INS_FRONT);

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        unique case (stat_i.action) inside
          dlle_pkg::ACT_INS_FRONT, dlle_pkg::ACT_INS_BACK: begin
            if (stat_i.pool_full) begin
              status_d = dlle_pkg::ST_FULL;
              vsel_d   = dlle_pkg::VSEL_CMD;
              state_d  = S_EMIT;
            end else begin
              cmd_o.alloc = 1'b1;
              state_d     = S_INS_LINK;
            end
          end
          dlle_pkg::ACT_DELETE: begin
            vsel_d = dlle_pkg::VSEL_CMD;
            if (stat_i.head_none) begin
              status_d = dlle_pkg::ST_EMPTY;
              state_d  = S_EMIT;
            end else begin
              cmd_o.cur_op   = dlle_pkg::CUR_HEAD;
              cmd_o.step_clr = 1'b1;
              state_d        = S_DEL_SCAN;
            end
          end
          dlle_pkg::ACT_WALK_FWD, dlle_pkg::ACT_WALK_BWD: begin
            if (walk_fwd ? stat_i.head_none : stat_i.tail_none) begin
              status_d = dlle_pkg::ST_EMPTY;
              vsel_d   = dlle_pkg::VSEL_ZERO;
              state_d  = S_EMIT;
            end else begin
              cmd_o.cur_op   = walk_fwd ? dlle_pkg::CUR_HEAD : dlle_pkg::CUR_TAIL;
              cmd_o.step_clr = 1'b1;
              state_d        = S_WALK;
            end
          end
          dlle_pkg::ACT_CLEAR: begin
            cmd_o.clear = 1'b1;
            status_d    = dlle_pkg::ST_OK;
            vsel_d      = dlle_pkg::VSEL_ZERO;
            state_d     = S_EMIT;
          end
          default: begin
            // unused action code: no word
            state_d = S_IDLE;
          end
        endcase
      end

      S_INS_LINK: begin
        cmd_o.ins_link = 1'b1;
        state_d        = S_INS_END;
      end

      S_INS_END: begin
        cmd_o.ins_end = 1'b1;
        status_d      = dlle_pkg::ST_OK;
        vsel_d        = dlle_pkg::VSEL_CMD;
        state_d       = S_EMIT;
      end

      S_DEL_SCAN: begin
        if (stat_i.node_match) begin
          cmd_o.unlink = 1'b1;
          status_d     = dlle_pkg::ST_OK;
          state_d      = S_EMIT;
        end else if (stat_i.next_none || stat_i.step_end) begin
          status_d = dlle_pkg::ST_NOT_FOUND;
          state_d  = S_EMIT;
        end else begin
          cmd_o.cur_op   = dlle_pkg::CUR_NEXT;
          cmd_o.step_inc = 1'b1;
        end
      end

      S_WALK: begin
        if (stat_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_sel    = dlle_pkg::VSEL_NODE;
          cmd_o.out_status = dlle_pkg::ST_OK;
          cmd_o.out_last   = walk_stop;
          if (walk_stop) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.cur_op   = walk_fwd ? dlle_pkg::CUR_NEXT : dlle_pkg::CUR_PREV;
            cmd_o.step_inc = 1'b1;
          end
        end
      end

      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= dlle_pkg::ST_OK;
      vsel_q   <= dlle_pkg::VSEL_CMD;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      vsel_q   <= vsel_d;
    end
  end

  a_emit_on_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && stat_i.out_free) |=> (state_q == S_IDLE))
    else $error("single-word result not followed by idle");

  a_walk_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && !stat_i.out_free) |=> (state_q == S_WALK))
    else $error("walk left its state while output was stalled");

endmodule

`default_nettype wire

/* src/doubly_linked_list_engine_unit.sv */
`default_nettype none

// Ordered list of signed 32-bit values kept in a pool of dlle_pkg::CAPACITY nodes.
// Input channel (in_valid_i / in_stall_o): action_i and value_i, one word per command.
// A command is taken only while the engine is idle; in_stall_o is high while it works.
// Output channel (out_valid_o / out_stall_i): out_value_o, status_o, is_last_o.
// Insert, delete, clear and empty walks give one word; a walk gives one word per node
// with is_last_o set on the final one. Unused action codes give no word.
// An insert goes through dispatch, link and end update, then loads its word in emit;
// clear, a full pool and an empty list go from dispatch straight to emit.
// Delete and walk visit one node per cycle, a walk only while output is not stalled;
// each node costs one read of the value and link RAMs. A new command is accepted
// in the cycle after the last word is registered, even if that word is still stalled.
// A stalled output word holds; the engine waits on the next word until it drains.
// Reset empties the list (every node free, no head or tail) and drops any
// pending output word. Node RAM contents are not cleared.

module doubly_linked_list_engine_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [2:0]                          action_i,
  input  wire logic signed [dlle_pkg::VALUE_W-1:0] value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [dlle_pkg::VALUE_W-1:0]      out_value_o,
  output logic [1:0]                               status_o,
  output logic                                     is_last_o
);

  dlle_pkg::dlle_cmd_t  cmd;
  dlle_pkg::dlle_stat_t stat;

  dlle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dlle_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .action_i    (action_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_value_o (out_value_o),
    .status_o    (status_o),
    .is_last_o   (is_last_o)
  );

endmodule

`default_nettype wire

/* tb/doubly_linked_list_engine_unit_check.sv */
module doubly_linked_list_engine_unit_check
  import dlle_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire logic [2:0]         action_i,
  input  wire logic [VALUE_W-1:0] value_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire logic [VALUE_W-1:0] out_value_i,
  input  wire logic [1:0]         status_i,
  input  wire logic               is_last_i,
  output int                      mismatch_count_o,
  output int                      words_due_o
);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    dlle_status_e       status;
    logic               last;
  } list_word_t;

  // shadow of the node pool
  logic [VALUE_W-1:0] node_val [0:CAPACITY-1];
  logic [IDX_W-1:0]   nxt_link [0:CAPACITY-1];
  logic [IDX_W-1:0]   prv_link [0:CAPACITY-1];
  logic [CAPACITY-1:0] free_map;
  logic [IDX_W-1:0]   head_idx;
  logic [IDX_W-1:0]   tail_idx;

  list_word_t due_words [$];

  initial begin
    mismatch_count_o = 0;
    words_due_o      = 0;
    free_map         = '1;
    head_idx         = IDX_NONE;
    tail_idx         = IDX_NONE;
  end

  function automatic void push_word(input logic [VALUE_W-1:0] v, input dlle_status_e s,
                                    input logic l);
    list_word_t w;
    w.value  = v;
    w.status = s;
    w.last   = l;
    due_words.push_back(w);
  endfunction

  task automatic list_apply(input logic [2:0] act, input logic [VALUE_W-1:0] val);
    int               i;
    int               slot;
    int               steps;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] cur;
    logic [IDX_W-1:0] nx;
    logic [IDX_W-1:0] p;
    logic [IDX_W-1:0] q;
    case (act)
      ACT_INS_FRONT, ACT_INS_BACK: begin
        slot = -1;
        for (i = 0; i < CAPACITY; i++) begin
          if (free_map[i] && slot < 0) slot = i;
        end
        if (slot < 0) begin
          push_word(val, ST_FULL, 1'b1);
        end else begin
          idx = IDX_W'(slot);
          free_map[slot] = 1'b0;
          node_val[idx] = val;
          if (act == ACT_INS_FRONT) begin
            prv_link[idx] = IDX_NONE;
            nxt_link[idx] = head_idx;
            if (head_idx != IDX_NONE) prv_link[head_idx] = idx;
            else tail_idx = idx;
            head_idx = idx;
          end else begin
            nxt_link[idx] = IDX_NONE;
            prv_link[idx] = tail_idx;
            if (tail_idx != IDX_NONE) nxt_link[tail_idx] = idx;
            else head_idx = idx;
            tail_idx = idx;
          end
          push_word(val, ST_OK, 1'b1);
        end
      end
      ACT_DELETE: begin
        if (head_idx == IDX_NONE) begin
          push_word(val, ST_EMPTY, 1'b1);
        end else begin
          cur   = head_idx;
          steps = 0;
          while (cur != IDX_NONE && steps < CAPACITY && node_val[cur] != val) begin
            cur = nxt_link[cur];
            steps++;
          end
          if (cur == IDX_NONE || steps >= CAPACITY) begin
            push_word(val, ST_NOT_FOUND, 1'b1);
          end else begin
            p = prv_link[cur];
            q = nxt_link[cur];
            if (p != IDX_NONE) nxt_link[p] = q;
            else head_idx = q;
            if (q != IDX_NONE) prv_link[q] = p;
            else tail_idx = p;
            free_map[cur] = 1'b1;
            push_word(val, ST_OK, 1'b1);
          end
        end
      end
      ACT_WALK_FWD, ACT_WALK_BWD: begin
        cur = (act == ACT_WALK_FWD) ? head_idx : tail_idx;
        if (cur == IDX_NONE) begin
          push_word('0, ST_EMPTY, 1'b1);
        end else begin
          steps = 0;
          while (cur != IDX_NONE && steps < CAPACITY) begin
            nx = (act == ACT_WALK_FWD) ? nxt_link[cur] : prv_link[cur];
            push_word(node_val[cur], ST_OK, (nx == IDX_NONE) || (steps + 1 >= CAPACITY));
            steps++;
            cur = nx;
          end
        end
      end
      ACT_CLEAR: begin
        free_map = '1;
        head_idx = IDX_NONE;
        tail_idx = IDX_NONE;
        push_word('0, ST_OK, 1'b1);
      end
      default: ;  // unused codes: no word, no change
    endcase
  endtask

  always @(posedge clk_i) begin
    list_word_t w;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (due_words.size() == 0) begin
          $display("%0t: unexpected word: expected none, got value %h status %0d last %b",
                   $time, out_value_i, status_i, is_last_i);
          mismatch_count_o++;
        end else begin
          w = due_words.pop_front();
          if (out_value_i !== w.value) begin
            $display("%0t: out_value: expected %h, got %h", $time, w.value, out_value_i);
            mismatch_count_o++;
          end
          if (status_i !== w.status) begin
            $display("%0t: status: expected %0d, got %0d", $time, w.status, status_i);
            mismatch_count_o++;
          end
          if (is_last_i !== w.last) begin
            $display("%0t: is_last: expected %b, got %b", $time, w.last, is_last_i);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) list_apply(action_i, value_i);
      words_due_o = due_words.size();
    end
  end

endmodule

/* tb/doubly_linked_list_engine_unit_tb.sv */
module doubly_linked_list_engine_unit_tb;
  import dlle_pkg::*;

  localparam logic [2:0] ACT_UNUSED_6 = 3'd6;
  localparam logic [2:0] ACT_UNUSED_7 = 3'd7;
  localparam int         RAND_ITEMS   = 210;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} cmd_mix_e;

  logic               clk_i     = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [2:0]         action    = ACT_WALK_FWD;
  logic [VALUE_W-1:0] value     = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [VALUE_W-1:0] out_value;
  logic [1:0]         status;
  logic               is_last;

  int                 mismatch_count;
  int                 words_due;
  int                 issued     = 0;
  int                 burst_left = 0;
  logic [VALUE_W-1:0] value_table [0:7];

  // receiver stall pattern
  int                 stall_mode = 0;
  int                 mode_left  = 0;
  int                 run_left   = 0;

  doubly_linked_list_engine_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .action_i    (action),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_value_o (out_value),
    .status_o    (status),
    .is_last_o   (is_last)
  );

  doubly_linked_list_engine_unit_check u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .action_i         (action),
    .value_i          (value),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_value_i      (out_value),
    .status_i         (status),
    .is_last_i        (is_last),
    .mismatch_count_o (mismatch_count),
    .words_due_o      (words_due)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left  <= $urandom_range(30, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: begin
        if (run_left == 0) begin
          out_stall <= ~out_stall;
          run_left  <= $urandom_range(1, 8);
        end else begin
          run_left <= run_left - 1;
        end
      end
    endcase
  end

  // mostly a small set of values so deletes hit and duplicates occur
  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return value_table[$urandom_range(0, 7)];
    if (r == 6) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom();
  endfunction

  task automatic send_cmd(input logic [2:0] act, input logic [VALUE_W-1:0] val);
    in_valid <= 1'b1;
    action   <= act;
    value    <= val;
    do @(posedge clk_i); while (in_stall);
    if (act <= ACT_CLEAR) issued++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 12);
    end
  endtask

  // fill the pool past capacity, then walk it both ways
  task automatic run_fill();
    int i;
    send_cmd(ACT_CLEAR, $urandom());
    for (i = 0; i < CAPACITY + 2; i++) begin
      send_cmd($urandom_range(0, 1) ? ACT_INS_BACK : ACT_INS_FRONT, pick_value());
    end
    send_cmd(ACT_WALK_FWD, $urandom());
    send_cmd(ACT_WALK_BWD, $urandom());
  endtask

  initial begin
    int       r;
    int       i;
    int       ins_pct;
    int       del_pct;
    int       phase_left;
    int       target;
    cmd_mix_e mix;
    for (i = 0; i < 8; i++) value_table[i] = $urandom();
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed part
    send_cmd(ACT_WALK_FWD, 32'h0);
    send_cmd(ACT_WALK_BWD, 32'hffff_ffff);
    send_cmd(ACT_DELETE, 32'h0000_0005);
    send_cmd(ACT_INS_FRONT, 32'h8000_0000);
    send_cmd(ACT_INS_BACK, 32'h7fff_ffff);
    send_cmd(ACT_INS_FRONT, 32'h0000_0000);
    send_cmd(ACT_INS_BACK, 32'hffff_ffff);
    send_cmd(ACT_INS_FRONT, 32'h0000_0000);
    send_cmd(ACT_WALK_FWD, 32'h0);
    send_cmd(ACT_WALK_BWD, 32'h0);
    send_cmd(ACT_DELETE, 32'h0000_1234);
    send_cmd(ACT_DELETE, 32'h0000_0000);
    send_cmd(ACT_DELETE, 32'hffff_ffff);
    send_cmd(ACT_DELETE, 32'h8000_0000);
    send_cmd(ACT_WALK_FWD, 32'h0);
    send_cmd(ACT_UNUSED_6, 32'h5555_5555);
    send_cmd(ACT_UNUSED_7, 32'haaaa_aaaa);
    send_cmd(ACT_CLEAR, 32'hffff_ffff);
    send_cmd(ACT_WALK_FWD, 32'h0);
    send_cmd(ACT_WALK_BWD, 32'h0);
    send_cmd(ACT_DELETE, 32'h0000_0000);
    send_cmd(ACT_INS_BACK, 32'h0000_0001);

    // random part
    target     = issued + RAND_ITEMS;
    phase_left = 0;
    mix        = MIX_GROW;
    run_fill();
    while (issued < target) begin
      if (phase_left == 0) begin
        mix        = cmd_mix_e'($urandom_range(0, 2));
        phase_left = $urandom_range(15, 40);
      end
      phase_left--;
      case (mix)
        MIX_GROW:   begin ins_pct = 70; del_pct = 10; end
        MIX_SHRINK: begin ins_pct = 20; del_pct = 55; end
        default:    begin ins_pct = 40; del_pct = 30; end
      endcase
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 149) == 0) run_fill();
      else if (r < 2)
        send_cmd($urandom_range(0, 1) ? ACT_UNUSED_6 : ACT_UNUSED_7, $urandom());
      else if (r < 5) send_cmd(ACT_CLEAR, $urandom());
      else if (r < 5 + ins_pct)
        send_cmd($urandom_range(0, 1) ? ACT_INS_BACK : ACT_INS_FRONT, pick_value());
      else if (r < 5 + ins_pct + del_pct) send_cmd(ACT_DELETE, pick_value());
      else send_cmd($urandom_range(0, 1) ? ACT_WALK_BWD : ACT_WALK_FWD, $urandom());
    end
    in_valid <= 1'b0;

    do @(negedge clk_i); while (words_due != 0);
    // catch any stray word after the last expected one
    repeat (50) @(negedge clk_i);
    if (mismatch_count == 0 && words_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
